[sv/mcr_pkg.sv]
package mcr_pkg;

  localparam int unsigned RampLengthMs = 30;
  localparam int unsigned RampIdxW     = (RampLengthMs > 1) ? $clog2(RampLengthMs) : 1;
  localparam int unsigned XW           = 15;
  localparam int unsigned SW           = 16;
  localparam int unsigned PolyW        = 17;
  localparam int unsigned SmoothPoly   = 3 * 32768;

  localparam int unsigned MulAW = 32;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned DataW  = 32;

  localparam logic signed [DataW-1:0] LevelScaleReset  = 32'sd262144;
  localparam logic signed [DataW-1:0] LevelOffsetReset = 32'sd0;

  localparam logic [6:0] ModeLowLimit  = 7'd32;
  localparam logic [6:0] ModeHighLimit = 7'd96;
  localparam logic [1:0] ModeLow  = 2'd0;
  localparam logic [1:0] ModeMid  = 2'd1;
  localparam logic [1:0] ModeHigh = 2'd2;

  localparam logic [15:0] CodeMax = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_RUN    = 2'd0,
    PH_DOWN   = 2'd1,
    PH_SWITCH = 2'd2,
    PH_UP     = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_GAIN,
    SQ_SQUARE,
    SQ_POLY,
    SQ_DELTA,
    SQ_APPLY
  } seq_e;

  typedef enum logic {
    REG_LEVEL_SCALE  = 1'b0,
    REG_LEVEL_OFFSET = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] level_scale;
    logic signed [DataW-1:0] level_offset;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        arm;
    logic [6:0]  level;
    logic        route_switch;
    logic [6:0]  mode_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] mute_code;
    logic        mute_written;
    logic [1:0]  mux_mode;
    logic        route_sel;
    logic        mux_changed;
    logic [1:0]  phase;
  } res_t;

  typedef logic [XW-1:0] x_lut_t [RampLengthMs];

  // ramp position in q15 for each elapsed millisecond
  function automatic x_lut_t build_x_lut();
    x_lut_t lut;
    for (int unsigned e = 0; e < RampLengthMs; e++) begin
      lut[e] = XW'((e * 32768) / RampLengthMs);
    end
    return lut;
  endfunction

  localparam x_lut_t XLut = build_x_lut();

endpackage

[sv/mcr_if.sv]
interface mcr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_ms;
  logic        arm;
  logic [6:0]  level;
  logic        route_switch;
  logic [6:0]  mode_value;

  modport source (
    output valid, command, now_ms, arm, level, route_switch, mode_value,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, arm, level, route_switch, mode_value,
    output ready
  );
endinterface

interface mcr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mute_code;
  logic        mute_written;
  logic [1:0]  mux_mode;
  logic        route_sel;
  logic        mux_changed;
  logic [1:0]  phase;

  modport source (
    output valid, mute_code, mute_written, mux_mode, route_sel, mux_changed, phase,
    input  ready
  );
  modport sink (
    input  valid, mute_code, mute_written, mux_mode, route_sel, mux_changed, phase,
    output ready
  );
endinterface

[sv/mcr_cfg_regs.sv]
module mcr_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcr_pkg::PaddrW-1:0]  paddr,
  input  logic [mcr_pkg::DataW-1:0]   pwdata,
  output logic [mcr_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output mcr_pkg::cfg_t               cfg_o
);
  import mcr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PaddrW-1]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LEVEL_SCALE:  cfg_d.level_scale  = $signed(pwdata);
        REG_LEVEL_OFFSET: cfg_d.level_offset = $signed(pwdata);
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEVEL_SCALE:  prdata = cfg_q.level_scale;
      REG_LEVEL_OFFSET: prdata = cfg_q.level_offset;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_scale  <= LevelScaleReset;
      cfg_q.level_offset <= LevelOffsetReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/mcr_mul_unit.sv]
module mcr_mul_unit (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [mcr_pkg::MulAW-1:0]   a_i,
  input  logic signed [mcr_pkg::MulBW-1:0]   b_i,
  output logic signed [mcr_pkg::MulPW-1:0]   prod_o
);
  import mcr_pkg::*;

  logic signed [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[sv/mute_crossfade_ramp_fsm.sv]
// Click-free mode and route switcher. Each input transfer is a millisecond tick or a
// mode control value and yields exactly one result transfer. A mode value's result is
// loaded in the apply step straight after acceptance, a tick's after the gain, square,
// polynomial and delta steps; the input is ready again once the result is loaded.
// These tick steps share the one registered 32x18 multiplier, used in turn for the
// level calibration, the square of the ramp position, the smoothstep polynomial and the
// scaling of the ramp step. A finished result waits in the output register while the
// next transfer is accepted; the next result is loaded only once that one is taken, so
// a stalled result side adds its stall cycles to the item. Mode and route changes
// ramp the mute code down over 30 ms, switch on the next tick, then ramp back up.
module mute_crossfade_ramp_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mcr_in_if.sink                      in_i,
  mcr_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcr_pkg::PaddrW-1:0]  paddr,
  input  logic [mcr_pkg::DataW-1:0]   pwdata,
  output logic [mcr_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import mcr_pkg::*;

  cfg_t cfg;

  seq_e     seq_q, seq_d;
  in_item_t item_q, item_in;
  logic     in_acc, out_free, apply_en, in_rdy;

  phase_e      phase_q, phase_d;
  logic [31:0] ramp_start_q, ramp_start_d;
  logic [15:0] level_held_q, level_held_d;
  logic [1:0]  pending_mode_q, pending_mode_d;
  logic        pending_route_q, pending_route_d;
  logic        route_applied_q, route_applied_d;
  logic [1:0]  mode_applied_q, mode_applied_d;

  logic [15:0]   tgt_q, tgt_d;
  logic [XW-1:0] x_q, x_d;
  logic          ramp_done_q, ramp_done_d;
  logic [31:0]   elapsed;

  res_t res_q, res_d;
  logic out_valid_q, out_valid_d;

  logic                    mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;

  logic signed [33:0] gain_sum;
  logic [PolyW-1:0]   poly;
  logic [SW-1:0]      s_val;
  logic signed [16:0] delta;
  logic [15:0]        ramp_from, ramp_to, ramp_code;
  logic [1:0]         mode_q8;

  mcr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcr_mul_unit u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign item_in.command      = in_i.command;
  assign item_in.now_ms       = in_i.now_ms;
  assign item_in.arm          = in_i.arm;
  assign item_in.level        = in_i.level;
  assign item_in.route_switch = in_i.route_switch;
  assign item_in.mode_value   = in_i.mode_value;

  assign in_i.ready = in_rdy;
  assign in_acc     = in_i.valid && in_rdy;
  assign out_free   = !out_valid_q || out_o.ready;

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SQ_IDLE:   if (in_acc) seq_d = in_i.command ? SQ_APPLY : SQ_GAIN;
      SQ_GAIN:   seq_d = SQ_SQUARE;
      SQ_SQUARE: seq_d = SQ_POLY;
      SQ_POLY:   seq_d = SQ_DELTA;
      SQ_DELTA:  seq_d = SQ_APPLY;
      SQ_APPLY:  if (out_free) seq_d = SQ_IDLE;
      default:   seq_d = SQ_IDLE;
    endcase
  end

  // ramp datapath
  assign elapsed     = item_q.now_ms - ramp_start_q;
  assign ramp_done_d = elapsed >= 32'(RampLengthMs);
  assign x_d         = ramp_done_d ? '0 : XLut[elapsed[RampIdxW-1:0]];
  assign poly        = PolyW'(SmoothPoly) - PolyW'({x_q, 1'b0});
  assign s_val       = prod[SW+29:30];
  assign delta       = (phase_q == PH_DOWN) ? -$signed({1'b0, level_held_q})
                                            : $signed({1'b0, tgt_q});

  assign gain_sum = prod[MulPW-1:16] + {{2{cfg.level_offset[DataW-1]}}, cfg.level_offset};
  always_comb begin
    if (!item_q.arm || gain_sum[33]) begin
      tgt_d = '0;
    end else if (|gain_sum[32:16]) begin
      tgt_d = CodeMax;
    end else begin
      tgt_d = gain_sum[15:0];
    end
  end

  // sequencer outputs
  always_comb begin
    in_rdy   = 1'b0;
    apply_en = 1'b0;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (seq_q)
      SQ_IDLE: in_rdy = 1'b1;
      SQ_GAIN: begin
        mul_en = 1'b1;
        mul_a  = cfg.level_scale;
        mul_b  = $signed(MulBW'({item_q.level, 7'd0}));
      end
      SQ_SQUARE: begin
        mul_en = 1'b1;
        mul_a  = $signed(MulAW'(x_q));
        mul_b  = $signed(MulBW'(x_q));
      end
      SQ_POLY: begin
        mul_en = 1'b1;
        mul_a  = $signed(MulAW'(prod[2*XW-1:0]));
        mul_b  = $signed(MulBW'(poly));
      end
      SQ_DELTA: begin
        mul_en = 1'b1;
        mul_a  = $signed(MulAW'(s_val));
        mul_b  = MulBW'(delta);
      end
      SQ_APPLY: apply_en = out_free;
      default: ;
    endcase
  end

  assign ramp_from = (phase_q == PH_DOWN) ? level_held_q : '0;
  assign ramp_to   = (phase_q == PH_DOWN) ? '0 : tgt_q;
  assign ramp_code = ramp_done_q ? ramp_to : ramp_from + prod[30:15];

  always_comb begin
    if (item_q.mode_value < ModeLowLimit) begin
      mode_q8 = ModeLow;
    end else if (item_q.mode_value < ModeHighLimit) begin
      mode_q8 = ModeMid;
    end else begin
      mode_q8 = ModeHigh;
    end
  end

  // block state update
  always_comb begin
    phase_d         = phase_q;
    ramp_start_d    = ramp_start_q;
    level_held_d    = level_held_q;
    pending_mode_d  = pending_mode_q;
    pending_route_d = pending_route_q;
    route_applied_d = route_applied_q;
    mode_applied_d  = mode_applied_q;
    res_d           = '0;
    if (item_q.command) begin
      if (mode_q8 != mode_applied_q) begin
        pending_mode_d  = mode_q8;
        pending_route_d = route_applied_q;
        if (phase_q == PH_RUN) begin
          phase_d      = PH_DOWN;
          ramp_start_d = item_q.now_ms;
        end
      end
    end else begin
      unique case (phase_q)
        PH_RUN: begin
          level_held_d       = tgt_q;
          res_d.mute_code    = tgt_q;
          res_d.mute_written = 1'b1;
        end
        PH_DOWN: begin
          res_d.mute_code    = ramp_code;
          res_d.mute_written = 1'b1;
          if (ramp_code == '0) phase_d = PH_SWITCH;
        end
        PH_SWITCH: begin
          mode_applied_d    = pending_mode_q;
          route_applied_d   = pending_route_q;
          res_d.mux_changed = 1'b1;
          phase_d           = PH_UP;
          ramp_start_d      = item_q.now_ms;
        end
        PH_UP: begin
          res_d.mute_code    = ramp_code;
          res_d.mute_written = 1'b1;
          if (ramp_code == tgt_q) begin
            level_held_d = tgt_q;
            phase_d      = PH_RUN;
          end
        end
        default: phase_d = phase_q;
      endcase
      if (item_q.route_switch != route_applied_d && phase_d == PH_RUN) begin
        pending_mode_d  = mode_applied_d;
        pending_route_d = item_q.route_switch;
        phase_d         = PH_DOWN;
        ramp_start_d    = item_q.now_ms;
      end
    end
    res_d.mux_mode  = mode_applied_d;
    res_d.route_sel = route_applied_d;
    res_d.phase     = phase_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (apply_en) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q           <= SQ_IDLE;
      out_valid_q     <= 1'b0;
      phase_q         <= PH_RUN;
      ramp_start_q    <= '0;
      level_held_q    <= '0;
      pending_mode_q  <= '0;
      pending_route_q <= 1'b0;
      route_applied_q <= 1'b0;
      mode_applied_q  <= '0;
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      if (apply_en) begin
        phase_q         <= phase_d;
        ramp_start_q    <= ramp_start_d;
        level_held_q    <= level_held_d;
        pending_mode_q  <= pending_mode_d;
        pending_route_q <= pending_route_d;
        route_applied_q <= route_applied_d;
        mode_applied_q  <= mode_applied_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= item_in;
    if (seq_q == SQ_GAIN) begin
      x_q         <= x_d;
      ramp_done_q <= ramp_done_d;
    end
    if (seq_q == SQ_SQUARE) tgt_q <= tgt_d;
    if (apply_en) res_q <= res_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mute_code    = res_q.mute_code;
  assign out_o.mute_written = res_q.mute_written;
  assign out_o.mux_mode     = res_q.mux_mode;
  assign out_o.route_sel    = res_q.route_sel;
  assign out_o.mux_changed  = res_q.mux_changed;
  assign out_o.phase        = res_q.phase;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input ready while a transfer is in progress");

  a_phase_only_on_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !apply_en |=> $stable(phase_q))
    else $error("phase changed outside the apply step");

  a_switch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.mux_changed) |->
      (phase_e'(out_o.phase) == PH_UP && !out_o.mute_written))
    else $error("switch step result is inconsistent");

  a_down_reaches_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.mute_written && phase_e'(out_o.phase) == PH_SWITCH) |->
      (out_o.mute_code == '0))
    else $error("switch entered before the mute code reached zero");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mcr_pkg::*;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    in_item_t    item;
    logic        typed;
    res_t        result;
    reg_idx_e    reg_idx;
    logic [31:0] reg_val;
  } stim_row_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PaddrW-1:0]   paddr   = '0;
  logic [DataW-1:0]    pwdata  = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  mcr_in_if  in_ch ();
  mcr_out_if out_ch ();

  mute_crossfade_ramp_fsm DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted switcher state and calibration
  phase_e             ph_now     = PH_RUN;
  logic [31:0]        ramp_t0    = '0;
  logic [15:0]        held_code  = '0;
  logic [1:0]         want_mode  = ModeLow;
  logic               want_route = 1'b0;
  logic [1:0]         mode_now   = ModeLow;
  logic               route_cur  = 1'b0;
  logic signed [31:0] gain_q16   = LevelScaleReset;
  logic signed [31:0] gain_ofs   = LevelOffsetReset;

  res_t        mute_results_due[$];
  stim_row_t   directed[$];
  int unsigned bad_count      = 0;
  int unsigned accepted       = 0;
  int unsigned checked        = 0;
  int unsigned switches_seen  = 0;
  int unsigned reg_writes     = 0;
  int unsigned in_gap         = 0;
  bit          in_burst       = 1'b0;
  bit          out_burst      = 1'b0;
  logic [31:0] clock_ms       = '0;
  logic [6:0]  level_knob     = '0;
  logic        route_pos      = 1'b0;

  function automatic void flag(string msg);
    bad_count++;
    if (bad_count <= 10) $display("%s", msg);
  endfunction

  function automatic string fmt_res(res_t r);
    return $sformatf("code=%0d wr=%0d mode=%0d route=%0d chg=%0d phase=%0d",
                     r.mute_code, r.mute_written, r.mux_mode, r.route_sel,
                     r.mux_changed, r.phase);
  endfunction

  function automatic logic [15:0] calibrated_code(logic arm, logic [6:0] level);
    longint signed acc;
    if (!arm) return 16'd0;
    acc = (longint'({level, 7'b0}) * longint'(gain_q16)) >>> 16;
    acc = acc + longint'(gain_ofs);
    if (acc < 0) acc = 0;
    if (acc > longint'(CodeMax)) acc = longint'(CodeMax);
    return acc[15:0];
  endfunction

  // smoothstep in q15, floor-scaled step between the two codes
  function automatic logic [15:0] smooth_code(logic [31:0] elapsed, logic [15:0] from,
                                              logic [15:0] to);
    longint unsigned x;
    longint unsigned s;
    longint signed   delta;
    if (elapsed >= RampLengthMs) return to;
    x = (64'(elapsed) << 15) / 64'(RampLengthMs);
    s = (x * x * (64'(SmoothPoly) - 2 * x)) >> 30;
    delta = ((longint'(to) - longint'(from)) * longint'(s)) >>> 15;
    return 16'(longint'(from) + delta);
  endfunction

  function automatic void raise_switch(logic [1:0] mode, logic route, logic [31:0] t);
    want_mode  = mode;
    want_route = route;
    if (ph_now == PH_RUN) begin
      ph_now  = PH_DOWN;
      ramp_t0 = t;
    end
  endfunction

  function automatic res_t step_crossfade(in_item_t it);
    res_t        r;
    logic [31:0] elapsed;
    logic [1:0]  m;
    logic [15:0] tgt;
    r = '0;
    if (it.command) begin
      m = (it.mode_value < ModeLowLimit) ? ModeLow :
          (it.mode_value < ModeHighLimit) ? ModeMid : ModeHigh;
      if (m != mode_now) raise_switch(m, route_cur, it.now_ms);
    end else begin
      elapsed = it.now_ms - ramp_t0;
      case (ph_now)
        PH_RUN: begin
          held_code      = calibrated_code(it.arm, it.level);
          r.mute_code    = held_code;
          r.mute_written = 1'b1;
        end
        PH_DOWN: begin
          r.mute_code    = smooth_code(elapsed, held_code, 16'd0);
          r.mute_written = 1'b1;
          if (r.mute_code == 16'd0) ph_now = PH_SWITCH;
        end
        PH_SWITCH: begin
          mode_now      = want_mode;
          route_cur     = want_route;
          r.mux_changed = 1'b1;
          ph_now        = PH_UP;
          ramp_t0       = it.now_ms;
        end
        default: begin
          tgt            = calibrated_code(it.arm, it.level);
          r.mute_code    = smooth_code(elapsed, 16'd0, tgt);
          r.mute_written = 1'b1;
          if (r.mute_code == tgt) begin
            held_code = tgt;
            ph_now    = PH_RUN;
          end
        end
      endcase
      if (it.route_switch != route_cur && ph_now == PH_RUN) begin
        raise_switch(mode_now, it.route_switch, it.now_ms);
      end
    end
    r.mux_mode  = mode_now;
    r.route_sel = route_cur;
    r.phase     = ph_now;
    return r;
  endfunction

  function automatic void add_tick(logic [31:0] t, logic arm, logic [6:0] lvl, logic sw);
    stim_row_t r;
    r                   = '0;
    r.kind              = ROW_ITEM;
    r.item.command      = 1'b0;
    r.item.now_ms       = t;
    r.item.arm          = arm;
    r.item.level        = lvl;
    r.item.route_switch = sw;
    r.item.mode_value   = 7'($urandom());
    directed.push_back(r);
  endfunction

  function automatic void add_mode(logic [31:0] t, logic [6:0] mval);
    stim_row_t r;
    r                   = '0;
    r.kind              = ROW_ITEM;
    r.item.command      = 1'b1;
    r.item.now_ms       = t;
    r.item.arm          = 1'($urandom());
    r.item.level        = 7'($urandom());
    r.item.route_switch = 1'($urandom());
    r.item.mode_value   = mval;
    directed.push_back(r);
  endfunction

  function automatic void add_cfg(reg_idx_e idx, logic [31:0] v);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = v;
    directed.push_back(r);
  endfunction

  function automatic void with_result(logic [15:0] code, logic wr, logic [1:0] mode,
                                      logic route, logic chg, phase_e ph);
    directed[directed.size()-1].typed  = 1'b1;
    directed[directed.size()-1].result = '{code, wr, mode, route, chg, ph};
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(1, 3);
    if ($urandom_range(0, 4) == 0) level_knob = 7'($urandom());
    if ($urandom_range(0, 29) == 0) route_pos = ~route_pos;
    it.command      = (roll >= 92);
    it.now_ms       = clock_ms;
    it.arm          = ($urandom_range(0, 9) != 0);
    it.level        = level_knob;
    it.route_switch = route_pos;
    it.mode_value   = 7'($urandom());
    return it;
  endfunction

  // called and returns at a falling edge
  task automatic send_item(in_item_t it, logic typed, res_t typed_res);
    res_t r;
    repeat (in_gap) @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.command      <= it.command;
    in_ch.now_ms       <= it.now_ms;
    in_ch.arm          <= it.arm;
    in_ch.level        <= it.level;
    in_ch.route_switch <= it.route_switch;
    in_ch.mode_value   <= it.mode_value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    r = step_crossfade(it);
    mute_results_due.push_back(typed ? typed_res : r);
    accepted++;
    if (accepted % 40 == 0) in_burst = ($urandom_range(0, 3) == 0);
    @(negedge clk_i);
    in_gap = in_burst ? 0 : $urandom_range(0, 9);
    if (in_gap != 0) in_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    if (in_gap == 0) in_ch.valid <= 1'b0;
    in_gap = 1;
    while (mute_results_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) flag($sformatf("reg %0d readback: expected %h, got %h", idx, val, rd));
    if (idx == REG_LEVEL_SCALE) gain_q16 = val;
    else gain_ofs = val;
    reg_writes++;
  endtask

  // result side: drop ready for a random stall before each transfer, or none during a burst
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ch.ready <= 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = out_burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (out_ch.valid !== 1'b1) @(posedge clk_i);
      taken++;
      if (taken % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.mute_code, out_ch.mute_written, out_ch.mux_mode, out_ch.route_sel,
              out_ch.mux_changed, out_ch.phase};
      if (mute_results_due.size() == 0) begin
        flag($sformatf("unexpected result transfer: %s", fmt_res(got)));
      end else begin
        want = mute_results_due.pop_front();
        checked++;
        if (got.mux_changed === 1'b1) switches_seen++;
        if (got.mute_code !== want.mute_code || got.mute_written !== want.mute_written ||
            got.mux_mode !== want.mux_mode || got.route_sel !== want.route_sel ||
            got.mux_changed !== want.mux_changed || got.phase !== want.phase) begin
          flag($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                         checked, fmt_res(want), fmt_res(got)));
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] scale_v;
    logic [31:0] ofs_v;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= 1'b0;
    in_ch.now_ms       <= '0;
    in_ch.arm          <= 1'b0;
    in_ch.level        <= '0;
    in_ch.route_switch <= 1'b0;
    in_ch.mode_value   <= '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_tick(0, 0, 0, 0);              with_result(0, 1, 0, 0, 0, PH_RUN);
    add_tick(1, 1, 127, 0);            with_result(65024, 1, 0, 0, 0, PH_RUN);
    add_mode(2, 0);                    with_result(0, 0, 0, 0, 0, PH_RUN);
    add_mode(10, 127);                 with_result(0, 0, 0, 0, 0, PH_DOWN);
    add_tick(10, 1, 127, 0);
    add_tick(25, 1, 127, 0);
    add_mode(26, 64);                  with_result(0, 0, 0, 0, 0, PH_DOWN);
    add_tick(40, 1, 127, 1);           with_result(0, 1, 0, 0, 0, PH_SWITCH);
    add_tick(41, 1, 127, 1);           with_result(0, 0, 1, 0, 1, PH_UP);
    add_tick(56, 1, 64, 1);
    add_tick(71, 1, 64, 1);
    // time wrapped behind the ramp start
    add_tick(5, 1, 64, 1);             with_result(0, 1, 1, 0, 0, PH_SWITCH);
    add_tick(6, 0, 0, 1);              with_result(0, 0, 1, 1, 1, PH_UP);
    add_tick(32'hFFFF_FFFF, 0, 0, 1);  with_result(0, 1, 1, 1, 0, PH_RUN);
    // ramp down from zero
    add_mode(100, 0);                  with_result(0, 0, 1, 1, 0, PH_DOWN);
    add_tick(101, 1, 127, 1);          with_result(0, 1, 1, 1, 0, PH_SWITCH);
    add_tick(102, 1, 127, 0);          with_result(0, 0, 0, 1, 1, PH_UP);
    add_tick(200, 0, 0, 1);            with_result(0, 1, 0, 1, 0, PH_RUN);
    // calibration saturation and floor rounding
    add_cfg(REG_LEVEL_SCALE, 32'h7FFF_FFFF);
    add_tick(201, 1, 127, 1);          with_result(65535, 1, 0, 1, 0, PH_RUN);
    add_cfg(REG_LEVEL_SCALE, 32'h8000_0000);
    add_tick(202, 1, 127, 1);          with_result(0, 1, 0, 1, 0, PH_RUN);
    add_cfg(REG_LEVEL_SCALE, 32'hFFFF_FFFF);
    add_cfg(REG_LEVEL_OFFSET, 32'd1);
    add_tick(203, 1, 1, 1);            with_result(0, 1, 0, 1, 0, PH_RUN);
    add_cfg(REG_LEVEL_OFFSET, 32'h7FFF_FFFF);
    add_tick(204, 1, 127, 1);          with_result(65535, 1, 0, 1, 0, PH_RUN);
    add_cfg(REG_LEVEL_OFFSET, 32'h8000_0000);
    add_tick(205, 0, 127, 1);          with_result(0, 1, 0, 1, 0, PH_RUN);
    // mode thresholds, pending mode overwritten during the ramp
    add_mode(206, 31);                 with_result(0, 0, 0, 1, 0, PH_RUN);
    add_mode(207, 32);                 with_result(0, 0, 0, 1, 0, PH_DOWN);
    add_mode(208, 96);
    add_mode(209, 95);
    add_tick(210, 1, 127, 1);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_item(directed[i].item, directed[i].typed, directed[i].result);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          scale_v = LevelScaleReset;
          ofs_v   = LevelOffsetReset;
        end
        1: begin
          scale_v = $urandom_range(0, 1 << 19);
          ofs_v   = 32'($urandom_range(0, 4000)) - 32'd2000;
        end
        2: begin
          scale_v = 32'h7FFF_FFFF;
          ofs_v   = 32'd0;
        end
        3: begin
          scale_v = $urandom();
          ofs_v   = $urandom();
        end
        4: begin
          scale_v = -32'($urandom_range(1, 1 << 19));
          ofs_v   = $urandom_range(0, 70000);
        end
        default: begin
          scale_v = 32'h8000_0000;
          ofs_v   = 32'h7FFF_FFFF;
        end
      endcase
      settle();
      write_reg(REG_LEVEL_SCALE, scale_v);
      write_reg(REG_LEVEL_OFFSET, ofs_v);
      clock_ms = (p == 3) ? 32'hFFFF_FFC0 : $urandom();
      for (int k = 0; k < 100; k++) send_item(random_item(), 1'b0, '0);
    end

    settle();
    $display("transfers in %0d, results checked %0d, mode/route switches %0d", accepted,
             checked, switches_seen);
    $display("register writes %0d, mismatches %0d", reg_writes, bad_count);
    if (bad_count == 0 && mute_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
